// ===== sv/ram_io_interval_timer_macros.svh =====
// ----------------------------------------------------------------------------
// RAM/IO/timer assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef RAM_IO_INTERVAL_TIMER_MACROS_SVH
`define RAM_IO_INTERVAL_TIMER_MACROS_SVH
`ifndef SYNTHESIS
`define RIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/rit_pkg.sv =====
// ----------------------------------------------------------------------------
// RAM/IO/timer package
// Shared request codes, register map, prescale table and controller links.
// ----------------------------------------------------------------------------
package rit_pkg;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_RAM_RD = 3'd1,
        REQ_RAM_WR = 3'd2,
        REQ_REG_RD = 3'd3,
        REQ_REG_WR = 3'd4
    } rit_req_t;

    localparam logic [4:0] REG_PA_DATA        = 5'h00;
    localparam logic [4:0] REG_PA_DIR         = 5'h01;
    localparam logic [4:0] REG_PB_DATA        = 5'h02;
    localparam logic [4:0] REG_PB_DIR         = 5'h03;
    localparam logic [4:0] REG_TIMER          = 5'h04;
    localparam logic [4:0] REG_STATUS         = 5'h05;
    localparam logic [4:0] REG_TMR_LOAD0      = 5'h14;
    localparam logic [4:0] REG_TMR_LOAD0_LAST = 5'h17;
    localparam logic [4:0] REG_TMR_LOAD1      = 5'h1C;
    localparam logic [4:0] REG_TMR_LOAD1_LAST = 5'h1F;

    localparam logic [7:0]  UNMAPPED_DATA = 8'hFF;
    localparam logic [7:0]  STATUS_FLAG   = 8'h80;
    localparam logic [7:0]  TIMER_RELOAD  = 8'hFF;
    localparam logic [10:0] DIV_1         = 11'd1;
    localparam logic [10:0] DIV_8         = 11'd8;
    localparam logic [10:0] DIV_64        = 11'd64;
    localparam logic [10:0] DIV_1024      = 11'd1024;

    typedef struct packed {
        logic capture;
        logic exec;
    } rit_cmd_t;

    typedef struct packed {
        logic req_valid;
    } rit_sts_t;

    function automatic logic [10:0] prescale_div(input logic [1:0] sel);
        logic [10:0] d;
        case (sel)
            2'd0:    d = DIV_1;
            2'd1:    d = DIV_8;
            2'd2:    d = DIV_64;
            default: d = DIV_1024;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/rit_ctrl.sv =====
// ----------------------------------------------------------------------------
// RAM/IO/timer controller
// Two-state sequencer: capture one word, then execute it when the result
// register is free; owns the result valid flag.
// ----------------------------------------------------------------------------
`include "ram_io_interval_timer_macros.svh"

module rit_ctrl
    import rit_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  rit_sts_t sts,
    output rit_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    assign slot_free   = !m_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_valid_reg;
    assign cmd.capture = s_tready && s_tvalid;
    assign cmd.exec    = (state_reg == ST_EXEC) && slot_free;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                    if (sts.req_valid) begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `RIT_ASSERT_IMP(a_exec_slot_free, aclk, aresetn, cmd.exec, !m_valid_reg || m_tready)
    `RIT_ASSERT_NXT(a_capture_to_exec, aclk, aresetn, cmd.capture, state_reg == ST_EXEC)
    `RIT_ASSERT_NXT(a_result_shown, aclk, aresetn, cmd.exec && sts.req_valid, m_tvalid)

endmodule

// ===== sv/rit_datapath.sv =====
// ----------------------------------------------------------------------------
// RAM/IO/timer datapath
// Request capture, RAM with per-byte valid bits, port and timer registers,
// and the result register.
// ----------------------------------------------------------------------------
module rit_datapath
    import rit_pkg::*;
#(
    parameter int RAM_DEPTH = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  rit_cmd_t   cmd,
    output rit_sts_t   sts,
    input  logic [2:0] in_req_type,
    input  logic [6:0] in_address,
    input  logic [7:0] in_write_value,
    input  logic [7:0] in_port_a_pins,
    input  logic [7:0] in_port_b_pins,
    output logic [7:0] read_data,
    output logic       timer_flag
);

    localparam int         AW       = $clog2(RAM_DEPTH);
    localparam int         MAX_WRAP = 128 / RAM_DEPTH;
    localparam logic [7:0] DEPTH_B  = 8'(RAM_DEPTH);

    function automatic logic [AW-1:0] wrap_index(input logic [6:0] a);
        logic [7:0] v;
        v = {1'b0, a};
        for (int i = 0; i < MAX_WRAP; i++) begin
            if (v >= DEPTH_B) begin
                v = v - DEPTH_B;
            end
        end
        return v[AW-1:0];
    endfunction

    logic [7:0]           mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] vld_reg;
    logic [7:0]           ram_q_reg;
    logic                 ram_qv_reg;

    logic [2:0]    req_reg;
    logic [4:0]    sel_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0]    wv_reg;
    logic [7:0]    pa_reg;
    logic [7:0]    pb_reg;

    logic [7:0]  pa_latch_reg, pa_latch_next;
    logic [7:0]  pa_dir_reg, pa_dir_next;
    logic [7:0]  pb_latch_reg, pb_latch_next;
    logic [7:0]  pb_dir_reg, pb_dir_next;
    logic [7:0]  count_reg, count_next;
    logic [10:0] div_reg, div_next;
    logic [10:0] presc_reg, presc_next;
    logic        expired_reg, expired_next;
    logic        flag_reg, flag_next;

    logic [7:0] rdata_reg;
    logic       tflag_reg;
    logic [7:0] rd_data;
    logic       ram_wr;

    assign sts.req_valid = (req_reg <= REQ_REG_WR);
    assign ram_wr        = cmd.exec && (req_reg == REQ_RAM_WR);
    assign read_data     = rdata_reg;
    assign timer_flag    = tflag_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg    <= in_req_type;
            sel_reg    <= in_address[4:0];
            idx_reg    <= wrap_index(in_address);
            wv_reg     <= in_write_value;
            pa_reg     <= in_port_a_pins;
            pb_reg     <= in_port_b_pins;
            ram_q_reg  <= mem[wrap_index(in_address)];
            ram_qv_reg <= vld_reg[wrap_index(in_address)];
        end
        if (ram_wr) begin
            mem[idx_reg] <= wv_reg;
        end
        if (cmd.exec && sts.req_valid) begin
            rdata_reg <= rd_data;
            tflag_reg <= flag_next;
        end
    end

    always_comb begin
        pa_latch_next = pa_latch_reg;
        pa_dir_next   = pa_dir_reg;
        pb_latch_next = pb_latch_reg;
        pb_dir_next   = pb_dir_reg;
        count_next    = count_reg;
        div_next      = div_reg;
        presc_next    = presc_reg;
        expired_next  = expired_reg;
        flag_next     = flag_reg;
        rd_data       = 8'h00;
        if (cmd.exec) begin
            case (req_reg)
                REQ_TICK: begin
                    if (div_reg != 11'd0) begin
                        if (presc_reg > 11'd1) begin
                            presc_next = presc_reg - 11'd1;
                        end else begin
                            presc_next = div_reg;
                            if (!expired_reg && count_reg == 8'h00) begin
                                count_next   = TIMER_RELOAD;
                                div_next     = DIV_1;
                                presc_next   = DIV_1;
                                expired_next = 1'b1;
                                flag_next    = 1'b1;
                            end else begin
                                count_next = count_reg - 8'd1;
                            end
                        end
                    end
                end
                REQ_RAM_RD: rd_data = ram_qv_reg ? ram_q_reg : 8'h00;
                REQ_REG_RD: begin
                    case (sel_reg)
                        REG_PA_DATA: rd_data = (pa_reg & ~pa_dir_reg) | (pa_latch_reg & pa_dir_reg);
                        REG_PA_DIR:  rd_data = pa_dir_reg;
                        REG_PB_DATA: rd_data = (pb_reg & ~pb_dir_reg) | (pb_latch_reg & pb_dir_reg);
                        REG_PB_DIR:  rd_data = pb_dir_reg;
                        REG_TIMER:   rd_data = count_reg;
                        REG_STATUS: begin
                            rd_data   = flag_reg ? STATUS_FLAG : 8'h00;
                            flag_next = 1'b0;
                        end
                        default:     rd_data = UNMAPPED_DATA;
                    endcase
                end
                REQ_REG_WR: begin
                    case (sel_reg) inside
                        REG_PA_DATA: pa_latch_next = wv_reg;
                        REG_PA_DIR:  pa_dir_next   = wv_reg;
                        REG_PB_DATA: pb_latch_next = wv_reg;
                        REG_PB_DIR:  pb_dir_next   = wv_reg;
                        [REG_TMR_LOAD0:REG_TMR_LOAD0_LAST],
                        [REG_TMR_LOAD1:REG_TMR_LOAD1_LAST]: begin
                            count_next   = wv_reg;
                            div_next     = prescale_div(sel_reg[1:0]);
                            presc_next   = prescale_div(sel_reg[1:0]);
                            expired_next = 1'b0;
                            flag_next    = 1'b0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            pa_latch_reg <= 8'h00;
            pa_dir_reg   <= 8'h00;
            pb_latch_reg <= 8'h00;
            pb_dir_reg   <= 8'h00;
            count_reg    <= 8'h00;
            div_reg      <= 11'd0;
            presc_reg    <= 11'd0;
            expired_reg  <= 1'b0;
            flag_reg     <= 1'b0;
        end else begin
            if (ram_wr) begin
                vld_reg[idx_reg] <= 1'b1;
            end
            pa_latch_reg <= pa_latch_next;
            pa_dir_reg   <= pa_dir_next;
            pb_latch_reg <= pb_latch_next;
            pb_dir_reg   <= pb_dir_next;
            count_reg    <= count_next;
            div_reg      <= div_next;
            presc_reg    <= presc_next;
            expired_reg  <= expired_next;
            flag_reg     <= flag_next;
        end
    end

endmodule

// ===== sv/ram_io_interval_timer.sv =====
// ----------------------------------------------------------------------------
// RAM, I/O and interval timer
// Usage:
//   Each input word is one request: tick, RAM read/write, register
//   read/write, with the request kind on s_tuser and the address, write
//   byte and both sampled pin bytes on s_tdata.
//   Every request of a known kind gives one output word holding the read
//   byte (zero for ticks and writes) and the timer flag after the request;
//   unknown kinds give no output word.
//   A word is accepted at an edge where s_tready is high and executed at
//   a later edge once the result register is free; its result shows on
//   m_tvalid right after that edge. s_tready stays low from capture until
//   execution, set by the capture/execute sequence of the controller.
//   The next word is accepted while a result waits on m_tvalid; when the
//   receiver stalls, execution holds and s_tready stays low until the
//   result register frees up.
//   Reset (aresetn low, synchronous) clears ports, timer, flag and marks
//   all RAM bytes as zero; no clearing sweep follows.
// ----------------------------------------------------------------------------
module ram_io_interval_timer
    import rit_pkg::*;
#(
    parameter int RAM_DEPTH = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[6:0], write_value[14:7],
                                   // port_a_pins[22:15], port_b_pins[30:23]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], timer_flag[8]
);

    rit_cmd_t   cmd;
    rit_sts_t   sts;
    logic [7:0] read_data;
    logic       timer_flag;

    assign m_tdata = {7'd0, timer_flag, read_data};

    rit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rit_datapath #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .in_req_type    (s_tuser),
        .in_address     (s_tdata[6:0]),
        .in_write_value (s_tdata[14:7]),
        .in_port_a_pins (s_tdata[22:15]),
        .in_port_b_pins (s_tdata[30:23]),
        .read_data      (read_data),
        .timer_flag     (timer_flag)
    );

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// RAM, I/O and interval timer testbench
// Drives request words (ticks, RAM and register accesses, reserved kinds)
// into the stream input. A behavioral copy of the RAM, port and timer state
// predicts every reply word. Replies are checked in order against that
// prediction while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import rit_pkg::*;

    localparam logic [2:0] REQ_RSVD_LO  = 3'd5;
    localparam logic [2:0] REQ_RSVD_HI  = 3'd7;
    localparam logic [4:0] REG_HOLE_LO  = 5'h08;
    localparam logic [4:0] REG_HOLE_HI  = 5'h10;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         PHASE_ITEMS  = 200;

    typedef struct packed {
        logic       flag;
        logic [7:0] data;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // address[6:0], write_value[14:7],
                                   // port_a_pins[22:15], port_b_pins[30:23]
    logic [2:0]  s_tuser = '0;     // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // read_data[7:0], timer_flag[8]

    logic [7:0]  ram_image [128];
    logic [7:0]  pa_latch, pa_dir, pb_latch, pb_dir;
    logic [7:0]  tmr_count;
    logic [10:0] tmr_div, tmr_pre;
    logic        tmr_expired, irq_flag;

    reply_t      pending_replies [$];
    int          mismatch_count = 0;
    int          requests_sent = 0;
    int          replies_checked = 0;
    int          expiry_count = 0;
    int          stall_cycles = 0;
    int          send_gap_pct = 0;
    int          recv_stall_pct = 0;

    ram_io_interval_timer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void clear_image();
        foreach (ram_image[i]) ram_image[i] = 8'h00;
        pa_latch = 8'h00;
        pa_dir = 8'h00;
        pb_latch = 8'h00;
        pb_dir = 8'h00;
        tmr_count = 8'h00;
        tmr_div = 11'd0;
        tmr_pre = 11'd0;
        tmr_expired = 1'b0;
        irq_flag = 1'b0;
    endfunction

    function automatic void timer_advance();
        if (tmr_div == 11'd0) return;
        if (tmr_pre > 11'd1) begin
            tmr_pre = tmr_pre - 11'd1;
            return;
        end
        tmr_pre = tmr_div;
        if (!tmr_expired && tmr_count == 8'h00) begin
            tmr_count = TIMER_RELOAD;
            tmr_div = DIV_1;
            tmr_pre = DIV_1;
            tmr_expired = 1'b1;
            irq_flag = 1'b1;
            expiry_count++;
        end else begin
            tmr_count = tmr_count - 8'd1;
        end
    endfunction

    function automatic logic [7:0] register_read(input logic [4:0] sel,
                                                 input logic [7:0] pins_a,
                                                 input logic [7:0] pins_b);
        logic [7:0] v;
        case (sel)
            REG_PA_DATA: v = (pins_a & ~pa_dir) | (pa_latch & pa_dir);
            REG_PA_DIR:  v = pa_dir;
            REG_PB_DATA: v = (pins_b & ~pb_dir) | (pb_latch & pb_dir);
            REG_PB_DIR:  v = pb_dir;
            REG_TIMER:   v = tmr_count;
            REG_STATUS: begin
                v = irq_flag ? STATUS_FLAG : 8'h00;
                irq_flag = 1'b0;
            end
            default:     v = UNMAPPED_DATA;
        endcase
        return v;
    endfunction

    function automatic void register_write(input logic [4:0] sel, input logic [7:0] v);
        logic [10:0] div;
        case (sel)
            REG_PA_DATA: pa_latch = v;
            REG_PA_DIR:  pa_dir = v;
            REG_PB_DATA: pb_latch = v;
            REG_PB_DIR:  pb_dir = v;
            default: begin
                if ((sel >= REG_TMR_LOAD0 && sel <= REG_TMR_LOAD0_LAST) ||
                    (sel >= REG_TMR_LOAD1 && sel <= REG_TMR_LOAD1_LAST)) begin
                    case (sel[1:0])
                        2'd0:    div = DIV_1;
                        2'd1:    div = DIV_8;
                        2'd2:    div = DIV_64;
                        default: div = DIV_1024;
                    endcase
                    tmr_count = v;
                    tmr_div = div;
                    tmr_pre = div;
                    tmr_expired = 1'b0;
                    irq_flag = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic bit predict_reply(input logic [2:0] kind, input logic [6:0] addr,
                                         input logic [7:0] wval, input logic [7:0] pins_a,
                                         input logic [7:0] pins_b, output reply_t r);
        bit known;
        known = 1'b1;
        r.data = 8'h00;
        case (kind)
            REQ_TICK:   timer_advance();
            REQ_RAM_RD: r.data = ram_image[addr];
            REQ_RAM_WR: ram_image[addr] = wval;
            REQ_REG_RD: r.data = register_read(addr[4:0], pins_a, pins_b);
            REQ_REG_WR: register_write(addr[4:0], wval);
            default:    known = 1'b0;
        endcase
        r.flag = irq_flag;
        return known;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < 40)
            $display("mismatch @%0t: %s got %02h want %02h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        reply_t r;
        reply_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (predict_reply(s_tuser, s_tdata[6:0], s_tdata[14:7], s_tdata[22:15],
                                  s_tdata[30:23], r))
                    pending_replies.push_back(r);
            end
            if (m_tvalid && m_tready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected word, data", m_tdata[7:0], 8'h00);
                end else begin
                    want = pending_replies.pop_front();
                    if (m_tdata[7:0] !== want.data)
                        report_mismatch("read_data", m_tdata[7:0], want.data);
                    if (m_tdata[8] !== want.flag)
                        report_mismatch("timer_flag", {7'd0, m_tdata[8]}, {7'd0, want.flag});
                    replies_checked++;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(input logic [2:0] kind, input logic [6:0] addr,
                             input logic [7:0] wval, input logic [7:0] pins_a,
                             input logic [7:0] pins_b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {1'b0, pins_b, pins_a, wval, addr};
        do @(posedge aclk); while (!s_tready);
        if (kind <= REQ_REG_WR) requests_sent++;
    endtask

    task automatic send_simple(input logic [2:0] kind, input logic [6:0] addr,
                               input logic [7:0] wval);
        send_word(kind, addr, wval, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic test_reset_values();
        send_simple(REQ_REG_RD, 7'(REG_STATUS), 8'h00);
        send_simple(REQ_TICK, 7'h00, 8'h00);
        send_simple(REQ_REG_RD, 7'(REG_TIMER), 8'h00);
        send_simple(REQ_RAM_RD, 7'h00, 8'h00);
    endtask

    task automatic test_ram_access();
        send_simple(REQ_RAM_WR, 7'h7F, 8'hFF);
        send_simple(REQ_RAM_RD, 7'h7F, 8'h00);
        send_simple(REQ_RAM_WR, 7'h00, 8'hA5);
        send_simple(REQ_RAM_RD, 7'h00, 8'h00);
    endtask

    task automatic test_port_io();
        send_simple(REQ_REG_WR, 7'(REG_PA_DIR), 8'hF0);
        send_simple(REQ_REG_WR, 7'(REG_PA_DATA), 8'hA5);
        send_word(REQ_REG_RD, 7'(REG_PA_DATA), 8'h00, 8'h3C, 8'h00);
        send_simple(REQ_REG_WR, 7'(REG_PB_DIR), 8'hFF);
        send_word(REQ_REG_RD, 7'(REG_PB_DATA), 8'h00, 8'h00, 8'hFF);
        send_simple(REQ_REG_RD, 7'(REG_PA_DIR), 8'h00);
    endtask

    task automatic test_timer_expiry();
        send_simple(REQ_REG_WR, 7'(REG_TMR_LOAD0), 8'h00);
        send_simple(REQ_TICK, 7'h00, 8'h00);
        send_simple(REQ_REG_RD, 7'(REG_TIMER), 8'h00);
        send_simple(REQ_TICK, 7'h00, 8'h00);
        send_simple(REQ_REG_RD, 7'(REG_STATUS), 8'h00);
        send_simple(REQ_REG_RD, 7'(REG_STATUS), 8'h00);
        send_simple(REQ_REG_WR, 7'h7F, 8'h00);
        send_simple(REQ_REG_RD, 7'(REG_TIMER), 8'h00);
    endtask

    task automatic test_bus_decode();
        send_simple(REQ_REG_RD, {2'b11, REG_HOLE_HI}, 8'h00);
        send_simple(REQ_REG_WR, 7'(REG_HOLE_LO), 8'h5A);
        for (int k = REQ_RSVD_LO; k <= REQ_RSVD_HI; k++)
            send_simple(k[2:0], 7'h7F, 8'hFF);
    endtask

    task automatic random_item();
        int p;
        logic [4:0] sel;
        p = $urandom_range(99);
        sel = ($urandom_range(99) < 80) ? 5'($urandom_range(5)) : 5'($urandom_range(31));
        if (p < 30) begin
            send_simple(REQ_TICK, 7'($urandom_range(127)), 8'($urandom_range(255)));
        end else if (p < 42) begin
            send_simple(REQ_RAM_RD, 7'($urandom_range(127)), 8'($urandom_range(255)));
        end else if (p < 55) begin
            send_simple(REQ_RAM_WR, 7'($urandom_range(127)), 8'($urandom_range(255)));
        end else if (p < 75) begin
            send_simple(REQ_REG_RD, {2'($urandom_range(3)), sel}, 8'($urandom_range(255)));
        end else if (p < 95) begin
            if ($urandom_range(99) < 25)
                sel = {1'b1, 1'($urandom_range(1)), 1'b1, 2'($urandom_range(3))};
            else if ($urandom_range(99) < 70)
                sel = 5'($urandom_range(3));
            send_simple(REQ_REG_WR, {2'($urandom_range(3)), sel}, 8'($urandom_range(255)));
        end else begin
            send_simple(3'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO)),
                        7'($urandom_range(127)), 8'($urandom_range(255)));
        end
    endtask

    task automatic timer_burst();
        int p;
        int sel;
        int div;
        int count;
        int ticks;
        p = $urandom_range(99);
        sel = (p < 45) ? 0 : (p < 80) ? 1 : (p < 95) ? 2 : 3;
        div = (sel == 0) ? 1 : (sel == 1) ? 8 : (sel == 2) ? 64 : 1024;
        if (sel == 3 || $urandom_range(99) < 8)
            count = $urandom_range(255);
        else
            count = (sel == 2) ? $urandom_range(1) : $urandom_range(6);
        ticks = (count + 1) * div + $urandom_range(4);
        if (ticks > 150) ticks = 150;
        send_simple(REQ_REG_WR, {2'($urandom_range(3)), 1'b1, 1'($urandom_range(1)), 1'b1,
                                 2'(sel)}, 8'(count));
        repeat (ticks) begin
            p = $urandom_range(99);
            if (p < 78)
                send_simple(REQ_TICK, 7'($urandom_range(127)), 8'($urandom_range(255)));
            else if (p < 88)
                send_simple(REQ_REG_RD, 7'(REG_TIMER), 8'($urandom_range(255)));
            else if (p < 96)
                send_simple(REQ_REG_RD, 7'(REG_STATUS), 8'($urandom_range(255)));
            else
                random_item();
        end
        send_simple(REQ_REG_RD, 7'(REG_STATUS), 8'($urandom_range(255)));
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct);
        int start;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        start = requests_sent;
        while (requests_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(99) < 12)
                timer_burst();
            else
                random_item();
        end
    endtask

    initial begin
        clear_image();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_ram_access();
        test_port_io();
        test_timer_expiry();
        test_bus_decode();
        test_random_traffic(0, 0);
        test_random_traffic(72, 0);
        test_random_traffic(0, 72);
        test_random_traffic(17, 17);
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("coverage: %0d requests sent, %0d replies checked, %0d timer expiries",
                 requests_sent, replies_checked, expiry_count);
        $display("phases: back-to-back, sender gaps, receiver stalls, mixed; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
